@@ src/refcounted_ldo_rail_manager_top_assert.svh @@
// Assertion macros for the rail manager top level.
`ifndef REFCOUNTED_LDO_RAIL_MANAGER_TOP_ASSERT_SVH
`define REFCOUNTED_LDO_RAIL_MANAGER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RLRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rail manager check failed");

// next-cycle implication, sampled on clk, off during reset
`define RLRM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rail manager check failed");

`endif

@@ src/rlrm_pkg.sv @@
`default_nettype none

package rlrm_pkg;

    typedef struct packed {
        logic        func;
        logic [2:0]  rail;
        logic [11:0] millivolts;
    } req_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
        logic [7:0] use_count;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [1:0] variant;
        logic [7:0] vbase;
        logic [7:0] en_addr;
    } cfg_t;

    // command handed from the front to the back
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  act;      // action of a single-beat command
        logic        buck;     // buck on (start) or buck off (stop) beat needed
        logic        low;      // voltage below minimum
        logic        grp;      // rails 0 and 1
        logic [1:0]  variant;
        logic [11:0] diff;     // millivolts above the minimum
        logic [7:0]  vaddr;
        logic [7:0]  en_addr;
        logic [7:0]  mirror;   // enable byte after this request
        logic [7:0]  cnt;
    } cmd_t;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_BUCK_ON  = 3'd1;
    localparam logic [2:0] ACT_BUCK_OFF = 3'd2;
    localparam logic [2:0] ACT_WRITE    = 3'd3;
    localparam logic [2:0] ACT_R7_ON    = 3'd4;
    localparam logic [2:0] ACT_R7_OFF   = 3'd5;
    localparam logic [2:0] ACT_LOW      = 3'd6;
    localparam logic [2:0] ACT_UNDER    = 3'd7;

    localparam logic FUNC_ENABLE  = 1'b0;
    localparam logic FUNC_DISABLE = 1'b1;

    localparam logic [1:0] VAR_WL  = 2'd0;
    localparam logic [1:0] VAR_ET  = 2'd1;
    localparam logic [1:0] VAR_FAN = 2'd2;

    localparam logic [1:0] CFG_VARIANT = 2'd0;
    localparam logic [1:0] CFG_VBASE   = 2'd1;
    localparam logic [1:0] CFG_EN_ADDR = 2'd2;

    localparam logic [1:0] VARIANT_RST = 2'd0;
    localparam logic [7:0] VBASE_RST   = 8'd3;
    localparam logic [7:0] EN_ADDR_RST = 8'd14;

    localparam logic [1:0] CMD_SINGLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    localparam logic [2:0] GPIO_RAIL   = 3'd7;
    localparam logic [7:0] WL_ALWAYS   = 8'h80;
    localparam logic [7:0] CNT_MAX     = 8'hFF;

    localparam logic [11:0] WL_MIN_LO  = 12'd496;
    localparam logic [11:0] WL_MIN_HI  = 12'd1504;
    localparam logic [11:0] ET_MIN_LO  = 12'd600;
    localparam logic [11:0] ET_MIN_HI  = 12'd1200;
    localparam logic [11:0] FAN_MIN_LO = 12'd800;
    localparam logic [11:0] FAN_MIN_HI = 12'd1500;
    localparam logic [7:0]  FAN_OFS_LO = 8'd99;
    localparam logic [7:0]  FAN_OFS_HI = 8'd16;

    // ceil(2^15 / 6) and ceil(2^15 / 10): exact for diff below 4096
    localparam logic [12:0] RECIP_6  = 13'd5462;
    localparam logic [12:0] RECIP_10 = 13'd3277;
    localparam int          RECIP_SH = 15;

    localparam int CMDQ_DEPTH = 2;

endpackage

`default_nettype wire

@@ src/rlrm_front.sv @@
`default_nettype none

module rlrm_front
    import rlrm_pkg::*;
#(
    parameter int NUM_RAILS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire req_t req,
    input  wire cfg_t cfg,
    input  wire logic q_full,
    output logic      q_wr,
    output cmd_t      q_wdata
);

    localparam int IDX_W = (NUM_RAILS > 1) ? $clog2(NUM_RAILS) : 1;

    logic [7:0] counts_reg [NUM_RAILS];
    logic [7:0] mirror_reg;
    logic [7:0] mirror_next;
    logic [7:0] cnt_next;
    logic       cnt_wr;

    logic             acc;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [7:0]       cnt_old;
    logic [7:0]       other_cnt;
    logic [7:0]       rail_bit;
    logic             grp;
    logic [11:0]      mv_min;
    cmd_t             cmd;

    assign acc = push && !q_full;
    assign q_wr = acc;
    assign q_wdata = cmd;

    assign in_range  = (32'(req.rail) < NUM_RAILS);
    assign idx       = req.rail[IDX_W-1:0];
    assign cnt_old   = counts_reg[idx];
    assign other_cnt = req.rail[0] ? counts_reg[0] : counts_reg[1];
    assign rail_bit  = 8'd1 << req.rail;
    assign grp       = (req.rail < 3'd2);

    always_comb
    begin
        case (cfg.variant)
            VAR_WL:  mv_min = grp ? WL_MIN_LO : WL_MIN_HI;
            VAR_FAN: mv_min = grp ? FAN_MIN_LO : FAN_MIN_HI;
            default: mv_min = grp ? ET_MIN_LO : ET_MIN_HI;
        endcase
    end

    always_comb
    begin
        cmd.kind    = CMD_SINGLE;
        cmd.act     = ACT_NONE;
        cmd.buck    = 1'b0;
        cmd.low     = (req.millivolts < mv_min);
        cmd.grp     = grp;
        cmd.variant = cfg.variant;
        cmd.diff    = req.millivolts - mv_min;
        cmd.vaddr   = cfg.vbase + {5'd0, req.rail};
        cmd.en_addr = cfg.en_addr;
        cmd.cnt     = 8'd0;
        mirror_next = mirror_reg;
        cnt_next    = cnt_old;
        cnt_wr      = 1'b0;
        if (in_range)
        begin
            if (req.func == FUNC_ENABLE)
            begin
                cnt_next = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 8'd1;
                cnt_wr   = 1'b1;
                cmd.cnt  = cnt_next;
                if (cnt_next != 8'd1)
                    cmd.act = ACT_NONE;
                else if (req.rail == GPIO_RAIL)
                    cmd.act = ACT_R7_ON;
                else
                begin
                    cmd.kind    = CMD_START;
                    cmd.buck    = grp;
                    mirror_next = mirror_reg | rail_bit |
                                  ((cfg.variant == VAR_WL) ? WL_ALWAYS : 8'd0);
                end
            end
            else if (cnt_old == 8'd0)
                cmd.act = ACT_UNDER;
            else
            begin
                cnt_next = cnt_old - 8'd1;
                cnt_wr   = 1'b1;
                cmd.cnt  = cnt_next;
                if (cnt_next != 8'd0)
                    cmd.act = ACT_NONE;
                else if (req.rail == GPIO_RAIL)
                    cmd.act = ACT_R7_OFF;
                else
                begin
                    cmd.kind    = CMD_STOP;
                    // buck drops once the partner rail is idle too
                    cmd.buck    = grp && (other_cnt == 8'd0);
                    mirror_next = mirror_reg & ~rail_bit;
                end
            end
        end
        cmd.mirror = mirror_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RAILS; i++)
                counts_reg[i] <= (i == 2) ? 8'd1 : 8'd0;
            mirror_reg <= 8'd0;
        end
        else if (acc)
        begin
            if (cnt_wr)
                counts_reg[idx] <= cnt_next;
            mirror_reg <= mirror_next;
        end
    end

endmodule

`default_nettype wire

@@ src/rlrm_cmd_queue.sv @@
`default_nettype none

module rlrm_cmd_queue
    import rlrm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire cmd_t wdata,
    output logic      full,
    input  wire logic rd,
    output logic      valid,
    output cmd_t      rdata
);

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             entries_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(CMDQ_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
            count_next = count_reg + CNT_W'(1);
        else if (rd && !wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= (32'(wr_ptr_reg) == CMDQ_DEPTH - 1) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
            if (rd)
                rd_ptr_reg <= (32'(rd_ptr_reg) == CMDQ_DEPTH - 1) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            entries_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

@@ src/rlrm_back.sv @@
`default_nettype none

module rlrm_back
    import rlrm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_rd,
    output logic      empty,
    input  wire logic pop,
    output rsp_t      rsp
);

    localparam logic [1:0] STEP_BUCK = 2'd0;
    localparam logic [1:0] STEP_VOLT = 2'd1;

    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic [1:0]  eff_step;
    logic        out_valid_reg;
    rsp_t        out_reg;
    rsp_t        beat;
    logic        emit;
    logic [24:0] prod;
    logic [7:0]  code;

    // ET divides by 6 or 10 through a reciprocal multiply
    assign prod = q_cmd.diff * (q_cmd.grp ? RECIP_6 : RECIP_10);

    always_comb
    begin
        case (q_cmd.variant)
            VAR_WL:  code = q_cmd.diff[10:3];
            VAR_FAN: code = q_cmd.diff[10:3] + (q_cmd.grp ? FAN_OFS_LO : FAN_OFS_HI);
            default: code = prod[RECIP_SH+7:RECIP_SH];
        endcase
    end

    // a start without buck skips the buck beat
    assign eff_step = step_reg + {1'b0, ~q_cmd.buck};

    always_comb
    begin
        beat.action    = q_cmd.act;
        beat.reg_addr  = 8'd0;
        beat.reg_data  = 8'd0;
        beat.use_count = q_cmd.cnt;
        beat.last      = 1'b1;
        case (q_cmd.kind)
            CMD_START:
            begin
                case (eff_step)
                    STEP_BUCK:
                    begin
                        beat.action = ACT_BUCK_ON;
                        beat.last   = 1'b0;
                    end
                    STEP_VOLT:
                    begin
                        beat.action   = q_cmd.low ? ACT_LOW : ACT_WRITE;
                        beat.reg_addr = q_cmd.vaddr;
                        beat.reg_data = q_cmd.low ? 8'd0 : code;
                        beat.last     = 1'b0;
                    end
                    default:
                    begin
                        beat.action   = ACT_WRITE;
                        beat.reg_addr = q_cmd.en_addr;
                        beat.reg_data = q_cmd.mirror;
                    end
                endcase
            end
            CMD_STOP:
            begin
                if (step_reg == 2'd0)
                begin
                    beat.action   = ACT_WRITE;
                    beat.reg_addr = q_cmd.en_addr;
                    beat.reg_data = q_cmd.mirror;
                    beat.last     = !q_cmd.buck;
                end
                else
                    beat.action = ACT_BUCK_OFF;
            end
            default:
            begin
                beat.action = q_cmd.act;
            end
        endcase
    end

    assign emit  = q_valid && (!out_valid_reg || pop);
    assign q_rd  = emit && beat.last;
    assign empty = !out_valid_reg;
    assign rsp   = out_reg;

    always_comb
    begin
        step_next = step_reg;
        if (emit)
            step_next = beat.last ? 2'd0 : step_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= beat;
    end

endmodule

`default_nettype wire

@@ src/refcounted_ldo_rail_manager_top.sv @@
// channel   dir  handshake              payload
// request   in   push / full            req   (func, rail, millivolts)
// result    out  empty / pop            rsp   (action, reg_addr, reg_data, use_count, last)
// config    in   cfg_we                 cfg_index, cfg_data
//
// A request passes the front combinationally; counts and enable mirror update there.
// The back emits one result beat per cycle while its output is empty or popped, so a
// request yields 1 to 3 result beats: a first enable of rail 0 or 1 is the 3-beat case.
// A two-entry command queue sits between the two; full rises only when it fills.
// Reset is asynchronous; counts come up zero except rail 2 at one.
`default_nettype none
`include "refcounted_ldo_rail_manager_top_assert.svh"

module refcounted_ldo_rail_manager_top
    import rlrm_pkg::*;
#(
    parameter int NUM_RAILS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire req_t       req,
    output logic            empty,
    input  wire logic       pop,
    output rsp_t            rsp,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_wr;
    cmd_t q_wdata;
    logic q_full;
    logic q_rd;
    logic q_valid;
    cmd_t q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.variant <= VARIANT_RST;
            cfg_reg.vbase   <= VBASE_RST;
            cfg_reg.en_addr <= EN_ADDR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VARIANT: cfg_reg.variant <= cfg_data[1:0];
                CFG_VBASE:   cfg_reg.vbase   <= cfg_data;
                CFG_EN_ADDR: cfg_reg.en_addr <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    assign full = q_full;

    rlrm_front #(
        .NUM_RAILS(NUM_RAILS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .req    (req),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_wdata(q_wdata)
    );

    rlrm_cmd_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (q_wr),
        .wdata(q_wdata),
        .full (q_full),
        .rd   (q_rd),
        .valid(q_valid),
        .rdata(q_rdata)
    );

    rlrm_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_cmd  (q_rdata),
        .q_rd   (q_rd),
        .empty  (empty),
        .pop    (pop),
        .rsp    (rsp)
    );

    // an accepted request is queued by the next edge
    `RLRM_ASSERT_NXT(a_req_queued, push && !full, q_valid)
    // underflow always reports a zero count
    `RLRM_ASSERT_IMP(a_under_cnt, !empty && rsp.action == ACT_UNDER, rsp.use_count == 8'd0)
    // buck on is never the last beat; the voltage beat follows it
    `RLRM_ASSERT_IMP(a_buck_on_mid, !empty && rsp.action == ACT_BUCK_ON, !rsp.last)

endmodule

`default_nettype wire
